### rtl/core/hufl_pkg.sv
// Shared definitions for the head unit frame link: protocol bytes, timer
// defaults, steering scale constants and the job word passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package hufl_pkg;

    // Frame and command bytes
    localparam logic [7:0] HDR_BYTE        = 8'h2E;
    localparam logic [7:0] CHK_XOR         = 8'hFF;
    localparam logic [7:0] REQ_VERSION     = 8'hC0;
    localparam logic [7:0] REQ_VERSION_ALT = 8'h08;
    localparam logic [7:0] REQ_ACK         = 8'h90;
    localparam logic [7:0] CMD_VERSION     = 8'hF1;
    localparam logic [7:0] CMD_ACK         = 8'h91;
    localparam logic [7:0] CMD_STEER       = 8'h26;
    localparam logic [7:0] CMD_DASH        = 8'h41;

    // Payload lengths
    localparam logic [4:0] LEN_VERSION = 5'd3;
    localparam logic [4:0] LEN_ACK     = 5'd2;
    localparam logic [4:0] LEN_STEER   = 5'd2;
    localparam logic [4:0] LEN_DASH    = 5'd13;

    // Fixed payload bytes
    localparam logic [7:0] VER_MAJOR   = 8'h02;
    localparam logic [7:0] VER_MINOR   = 8'h08;
    localparam logic [7:0] VER_PATCH   = 8'h10;
    localparam logic [7:0] ACK_BYTE0   = 8'h41;
    localparam logic [7:0] ACK_BYTE1   = 8'h02;
    localparam logic [7:0] DASH_TAG    = 8'h02;
    localparam logic [7:0] DASH_FLAGS  = 8'h04;
    localparam logic [7:0] DOOR_TAG    = 8'h01;

    // Configuration register indexes and reset values
    localparam logic CFG_FAST_PERIOD = 1'b0;
    localparam logic CFG_SLOW_PERIOD = 1'b1;
    localparam logic [15:0] FAST_PERIOD_RESET = 16'd100;
    localparam logic [15:0] SLOW_PERIOD_RESET = 16'd400;
    localparam logic [7:0]  DOORS_RESET       = 8'hFF;

    // Steering scale: angle = trunc((pos + 500) * 54 / 5) - 5400
    localparam logic signed [16:0] STEER_OFFSET = 17'sd500;
    localparam logic [20:0] STEER_GAIN  = 21'd54;
    localparam logic [19:0] DIV5_RECIP  = 20'd838861;
    localparam int          DIV5_SHIFT  = 22;
    localparam logic [15:0] ANGLE_BIAS  = 16'd5400;

    // Job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One word per item that sends at least one frame
    typedef struct packed {
        logic        ver;
        logic        ack;
        logic        steer;
        logic        dash;
        logic        door;
        logic [15:0] angle;
        logic [15:0] rpm;
        logic [15:0] battery;
        logic [15:0] temp;
        logic [7:0]  fuel;
        logic [4:0]  door_map;
    } hufl_job_t;

endpackage

### rtl/core/hufl_front.sv
// Front end: accepts words, runs the receive parser, tick timers and door
// compare, scales the steering angle and hands frame jobs to the queue.
// Depends on hufl_pkg.
`timescale 1ns / 1ps

module hufl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_rx_byte,
    input  logic signed [15:0]  s_steer_position,
    input  logic [15:0]         s_engine_rpm,
    input  logic [15:0]         s_battery_centivolts,
    input  logic signed [15:0]  s_outside_temp_tenths,
    input  logic [7:0]          s_fuel_level,
    input  logic [7:0]          s_door_bits,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [15:0]         cfg_wdata,
    output logic                push_valid,
    output hufl_pkg::hufl_job_t push_job,
    input  logic                queue_full
);
    import hufl_pkg::*;

    typedef enum logic [1:0] {PH_HUNT, PH_CMD, PH_LEN, PH_SKIP} phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [8:0]  skip_reg, skip_next;
    logic [15:0] fast_reg, fast_next;
    logic [15:0] slow_reg, slow_next;
    logic [7:0]  doors_reg, doors_next;
    logic [15:0] fast_period_reg;
    logic [15:0] slow_period_reg;

    logic        v1_reg, v2_reg;
    hufl_job_t   job1_reg, job2_reg, job1_next;
    logic [20:0] mag1_reg;
    logic        neg1_reg, neg2_reg;
    logic [15:0] quot2_reg;

    logic        accept, en1, en2, push_ok, job2_any;
    logic        ver_hit, ack_hit;
    logic [15:0] fast_inc, slow_inc;
    logic        fast_fire, slow_fire, door_diff;
    logic signed [16:0] pos_sum;
    logic [16:0] pos_neg;
    logic        pos_is_neg;
    logic [15:0] pos_abs;
    logic [20:0] mag_next;
    logic [40:0] recip_prod;
    logic [15:0] signed_quot;

    assign job2_any = job2_reg.ver | job2_reg.ack | job2_reg.steer
                    | job2_reg.dash | job2_reg.door;
    assign push_ok  = !queue_full || !job2_any;
    assign en2      = !v2_reg || push_ok;
    assign en1      = !v1_reg || en2;
    assign s_ready  = en1;
    assign accept   = s_valid && s_ready;

    // Receive parser
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        skip_next  = skip_reg;
        ver_hit    = 1'b0;
        ack_hit    = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                if (s_rx_byte == HDR_BYTE) begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_next   = s_rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                skip_next  = 9'(s_rx_byte) + 9'd1;
                phase_next = PH_SKIP;
            end
            PH_SKIP: begin
                if (skip_reg > 9'd1) begin
                    skip_next = skip_reg - 9'd1;
                end else begin
                    skip_next  = 9'd0;
                    phase_next = PH_HUNT;
                    ver_hit    = (cmd_reg == REQ_VERSION) || (cmd_reg == REQ_VERSION_ALT);
                    ack_hit    = (cmd_reg == REQ_ACK);
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Tick timers saturate at full scale and restart when they fire.
    assign fast_inc  = (fast_reg == 16'hFFFF) ? fast_reg : fast_reg + 16'd1;
    assign slow_inc  = (slow_reg == 16'hFFFF) ? slow_reg : slow_reg + 16'd1;
    assign fast_fire = (fast_inc >= fast_period_reg);
    assign slow_fire = (slow_inc >= slow_period_reg);
    assign fast_next = fast_fire ? 16'd0 : fast_inc;
    assign slow_next = slow_fire ? 16'd0 : slow_inc;
    assign door_diff = (s_door_bits != doors_reg);
    assign doors_next = s_door_bits;

    // Steering magnitude: |pos + 500| * 54, sign kept aside for truncation toward zero.
    assign pos_sum    = 17'(s_steer_position) + STEER_OFFSET;
    assign pos_neg    = 17'(-pos_sum);
    assign pos_is_neg = pos_sum[16];
    assign pos_abs    = pos_is_neg ? pos_neg[15:0] : pos_sum[15:0];
    assign mag_next   = 21'(pos_abs) * STEER_GAIN;

    always_comb begin
        job1_next          = '0;
        job1_next.ver      = !s_kind && ver_hit;
        job1_next.ack      = !s_kind && ack_hit;
        job1_next.steer    = s_kind && fast_fire;
        job1_next.dash     = s_kind && slow_fire;
        job1_next.door     = s_kind && door_diff;
        job1_next.rpm      = s_engine_rpm;
        job1_next.battery  = s_battery_centivolts;
        job1_next.temp     = s_outside_temp_tenths;
        job1_next.fuel     = s_fuel_level;
        job1_next.door_map = {s_door_bits[3], s_door_bits[4], s_door_bits[5],
                              s_door_bits[6], s_door_bits[7]};
    end

    // Divide by five through the reciprocal; exact for magnitudes below 2^22.
    assign recip_prod  = 41'(mag1_reg) * 41'(DIV5_RECIP);
    assign signed_quot = neg2_reg ? (~quot2_reg + 16'd1) : quot2_reg;

    always_comb begin
        push_job       = job2_reg;
        push_job.angle = signed_quot - ANGLE_BIAS;
    end
    assign push_valid = v2_reg && job2_any;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            cmd_reg         <= 8'd0;
            skip_reg        <= 9'd0;
            fast_reg        <= 16'd0;
            slow_reg        <= 16'd0;
            doors_reg       <= DOORS_RESET;
            fast_period_reg <= FAST_PERIOD_RESET;
            slow_period_reg <= SLOW_PERIOD_RESET;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FAST_PERIOD: fast_period_reg <= cfg_wdata;
                    CFG_SLOW_PERIOD: slow_period_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_kind) begin
                    fast_reg  <= fast_next;
                    slow_reg  <= slow_next;
                    doors_reg <= doors_next;
                end else begin
                    phase_reg <= phase_next;
                    cmd_reg   <= cmd_next;
                    skip_reg  <= skip_next;
                end
            end
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            job1_reg <= job1_next;
            mag1_reg <= mag_next;
            neg1_reg <= pos_is_neg;
        end
        if (en2) begin
            job2_reg  <= job1_reg;
            quot2_reg <= recip_prod[DIV5_SHIFT+15:DIV5_SHIFT];
            neg2_reg  <= neg1_reg;
        end
    end

    a_skip_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (skip_reg != 9'd0))
        else $error("skip count empty while skipping");

    a_skip_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_SKIP) |-> (skip_reg == 9'd0))
        else $error("skip count left over outside of skipping");

    a_ack_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_kind && phase_reg == PH_SKIP && skip_reg == 9'd1
         && cmd_reg == REQ_ACK) |=> (v1_reg && job1_reg.ack && !job1_reg.ver))
        else $error("acknowledge request did not raise an acknowledge job");

endmodule

### rtl/core/hufl_queue.sv
// Short job queue between the front end and the frame serializer.
// Depends on hufl_pkg.
`timescale 1ns / 1ps

module hufl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  hufl_pkg::hufl_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output hufl_pkg::hufl_job_t pop_job
);
    import hufl_pkg::*;

    hufl_job_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/core/hufl_back.sv
// Frame serializer: takes one job at a time and sends its frames byte by byte
// through an output register. Depends on hufl_pkg.
`timescale 1ns / 1ps

module hufl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                empty,
    input  hufl_pkg::hufl_job_t pop_job,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_tx_byte,
    output logic                m_frame_end,
    output logic                m_last
);
    import hufl_pkg::*;

    typedef enum logic [2:0] {FR_VER, FR_ACK, FR_STEER, FR_DASH, FR_DOOR} frame_t;

    localparam logic [4:0] POS_HDR     = 5'd0;
    localparam logic [4:0] POS_CMD     = 5'd1;
    localparam logic [4:0] POS_LEN     = 5'd2;
    localparam logic [4:0] POS_PAYLOAD = 5'd3;

    logic        busy_reg;
    hufl_job_t   job_reg;
    logic [4:0]  mask_reg, mask_clr;
    logic [4:0]  pos_reg;
    logic [7:0]  sum_reg;
    logic        m_valid_reg;
    logic [7:0]  tx_reg;
    logic        end_reg, last_reg;

    frame_t      cur;
    logic [7:0]  cur_cmd;
    logic [4:0]  cur_len;
    logic [4:0]  pay_off;
    logic [3:0]  pay_idx;
    logic [7:0]  pay_byte, tx_byte;
    logic        is_check, out_en, step;

    assign out_en   = !m_valid_reg || m_ready;
    assign step     = busy_reg && out_en;
    assign pop      = !busy_reg && !empty;
    assign mask_clr = mask_reg & (mask_reg - 5'd1);

    always_comb begin
        if (mask_reg[0]) begin
            cur = FR_VER;
        end else if (mask_reg[1]) begin
            cur = FR_ACK;
        end else if (mask_reg[2]) begin
            cur = FR_STEER;
        end else if (mask_reg[3]) begin
            cur = FR_DASH;
        end else begin
            cur = FR_DOOR;
        end
    end

    assign pay_off = pos_reg - POS_PAYLOAD;
    assign pay_idx = pay_off[3:0];

    always_comb begin
        cur_cmd  = CMD_DASH;
        cur_len  = LEN_DASH;
        pay_byte = 8'd0;
        case (cur)
            FR_VER: begin
                cur_cmd = CMD_VERSION;
                cur_len = LEN_VERSION;
                case (pay_idx)
                    4'd0:    pay_byte = VER_MAJOR;
                    4'd1:    pay_byte = VER_MINOR;
                    default: pay_byte = VER_PATCH;
                endcase
            end
            FR_ACK: begin
                cur_cmd  = CMD_ACK;
                cur_len  = LEN_ACK;
                pay_byte = (pay_idx == 4'd0) ? ACK_BYTE0 : ACK_BYTE1;
            end
            FR_STEER: begin
                cur_cmd  = CMD_STEER;
                cur_len  = LEN_STEER;
                pay_byte = (pay_idx == 4'd0) ? job_reg.angle[7:0] : job_reg.angle[15:8];
            end
            FR_DASH: begin
                case (pay_idx)
                    4'd0:    pay_byte = DASH_TAG;
                    4'd1:    pay_byte = job_reg.rpm[15:8];
                    4'd2:    pay_byte = job_reg.rpm[7:0];
                    4'd5:    pay_byte = job_reg.battery[15:8];
                    4'd6:    pay_byte = job_reg.battery[7:0];
                    4'd7:    pay_byte = job_reg.temp[15:8];
                    4'd8:    pay_byte = job_reg.temp[7:0];
                    4'd11:   pay_byte = DASH_FLAGS;
                    4'd12:   pay_byte = job_reg.fuel;
                    default: pay_byte = 8'd0;
                endcase
            end
            FR_DOOR: begin
                case (pay_idx)
                    4'd0:    pay_byte = DOOR_TAG;
                    4'd1:    pay_byte = {3'd0, job_reg.door_map};
                    default: pay_byte = 8'd0;
                endcase
            end
            default: begin
                pay_byte = 8'd0;
            end
        endcase
    end

    assign is_check = (pos_reg == cur_len + POS_PAYLOAD);

    always_comb begin
        case (pos_reg)
            POS_HDR: tx_byte = HDR_BYTE;
            POS_CMD: tx_byte = cur_cmd;
            POS_LEN: tx_byte = {3'd0, cur_len};
            default: tx_byte = is_check ? (sum_reg ^ CHK_XOR) : pay_byte;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            mask_reg    <= 5'd0;
            pos_reg     <= POS_HDR;
            sum_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
                mask_reg <= {pop_job.door, pop_job.dash, pop_job.steer,
                             pop_job.ack, pop_job.ver};
                pos_reg  <= POS_HDR;
                sum_reg  <= 8'd0;
            end else if (step) begin
                if (is_check) begin
                    pos_reg  <= POS_HDR;
                    sum_reg  <= 8'd0;
                    mask_reg <= mask_clr;
                    busy_reg <= (mask_clr != 5'd0);
                end else begin
                    pos_reg <= pos_reg + 5'd1;
                    // The header byte stays out of the checksum.
                    if (pos_reg != POS_HDR) begin
                        sum_reg <= sum_reg + tx_byte;
                    end
                end
            end
            if (out_en) begin
                m_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= pop_job;
        end
        if (step) begin
            tx_reg   <= tx_byte;
            end_reg  <= is_check;
            last_reg <= is_check && (mask_clr == 5'd0);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = tx_reg;
    assign m_frame_end = end_reg;
    assign m_last      = last_reg;

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg) |-> end_reg)
        else $error("last word is not a checksum word");

    a_busy_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (mask_reg != 5'd0))
        else $error("serializer busy with no frame left");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg <= cur_len + POS_PAYLOAD))
        else $error("byte position ran past the checksum");

endmodule

### rtl/core/head_unit_frame_link.sv
// Head unit frame link: an item's frame words pass through the front pipeline, the
// job queue and the output register, then leave at one per cycle while m_ready is
// high; the serializer pops a job only after the last one is sent. Up to 4 jobs wait
// in the queue, so items are taken every cycle until it fills. A tick sends at most
// 40 words. aresetn is synchronous and active low: the parser hunts for a header,
// timers clear, periods return to 100 and 400, doors to 0xFF.
`timescale 1ns / 1ps

module head_unit_frame_link (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_rx_byte,
    input  logic signed [15:0] s_steer_position,
    input  logic [15:0]        s_engine_rpm,
    input  logic [15:0]        s_battery_centivolts,
    input  logic signed [15:0] s_outside_temp_tenths,
    input  logic [7:0]         s_fuel_level,
    input  logic [7:0]         s_door_bits,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_tx_byte,
    output logic               m_frame_end,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    import hufl_pkg::*;

    logic      push_valid, queue_full, queue_empty, pop;
    hufl_job_t push_job, pop_job;

    hufl_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_kind                (s_kind),
        .s_rx_byte             (s_rx_byte),
        .s_steer_position      (s_steer_position),
        .s_engine_rpm          (s_engine_rpm),
        .s_battery_centivolts  (s_battery_centivolts),
        .s_outside_temp_tenths (s_outside_temp_tenths),
        .s_fuel_level          (s_fuel_level),
        .s_door_bits           (s_door_bits),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_addr              (cfg_addr),
        .cfg_wdata             (cfg_wdata),
        .push_valid            (push_valid),
        .push_job              (push_job),
        .queue_full            (queue_full)
    );

    hufl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .pop_job    (pop_job)
    );

    hufl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .empty       (queue_empty),
        .pop_job     (pop_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_byte   (m_tx_byte),
        .m_frame_end (m_frame_end),
        .m_last      (m_last)
    );

endmodule

### dv/head_unit_frame_link_test.sv
// Self-checking testbench for head_unit_frame_link: drives serial bytes and millisecond
// ticks, predicts every frame word the link sends, and compares them in order.
// Depends on rtl/core/hufl_pkg.sv and rtl/core/head_unit_frame_link.sv.
`timescale 1ns / 1ps

module head_unit_frame_link_test;
    import hufl_pkg::*;

    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic [7:0] UNKNOWN_CMD = 8'h33;
    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 500;

    typedef enum logic [1:0] {HUNT_HDR, TAKE_CMD, TAKE_LEN, SKIP_BODY} parse_phase_e;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [15:0] steer;
        logic [15:0] rpm;
        logic [15:0] battery;
        logic [15:0] temp;
        logic [7:0]  fuel;
        logic [7:0]  doors;
    } link_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       last;
    } tx_word_t;

    // Predicts the words sent for each accepted input and checks them in order.
    class tx_frame_board;
        tx_word_t     frames_due[$];
        parse_phase_e phase;
        logic [7:0]   cmd_seen;
        logic [8:0]   bytes_to_skip;
        logic [15:0]  fast_count;
        logic [15:0]  slow_count;
        logic [15:0]  fast_period;
        logic [15:0]  slow_period;
        logic [7:0]   doors_sent;
        int           errors;

        function new();
            phase       = HUNT_HDR;
            cmd_seen    = 8'h00;
            bytes_to_skip = 9'd0;
            fast_count  = 16'd0;
            slow_count  = 16'd0;
            fast_period = FAST_PERIOD_RESET;
            slow_period = SLOW_PERIOD_RESET;
            doors_sent  = DOORS_RESET;
            errors      = 0;
        endfunction

        function void set_periods(logic [15:0] fast, logic [15:0] slow);
            fast_period = fast;
            slow_period = slow;
        endfunction

        function void add_frame(logic [7:0] cmd, int len, logic [7:0] pay [13]);
            logic [7:0] sum;
            sum = cmd + 8'(len);
            frames_due.push_back('{HDR_BYTE, 1'b0, 1'b0});
            frames_due.push_back('{cmd, 1'b0, 1'b0});
            frames_due.push_back('{8'(len), 1'b0, 1'b0});
            for (int i = 0; i < len; i++) begin
                sum = sum + pay[i];
                frames_due.push_back('{pay[i], 1'b0, 1'b0});
            end
            frames_due.push_back('{sum ^ CHK_XOR, 1'b1, 1'b0});
        endfunction

        function void take_item(link_item_t it);
            logic [7:0]  pay [13];
            logic [15:0] a16;
            tx_word_t    w;
            int          pos;
            int          ang;
            int          first;
            first = frames_due.size();
            foreach (pay[i]) pay[i] = 8'h00;
            if (it.kind == KIND_RX) begin
                case (phase)
                    HUNT_HDR: if (it.rx_byte == HDR_BYTE) phase = TAKE_CMD;
                    TAKE_CMD: begin
                        cmd_seen = it.rx_byte;
                        phase = TAKE_LEN;
                    end
                    TAKE_LEN: begin
                        bytes_to_skip = {1'b0, it.rx_byte} + 9'd1;
                        phase = SKIP_BODY;
                    end
                    default: begin
                        if (bytes_to_skip > 9'd1) begin
                            bytes_to_skip = bytes_to_skip - 9'd1;
                        end else begin
                            bytes_to_skip = 9'd0;
                            phase = HUNT_HDR;
                            if (cmd_seen == REQ_VERSION || cmd_seen == REQ_VERSION_ALT) begin
                                pay[0] = VER_MAJOR;
                                pay[1] = VER_MINOR;
                                pay[2] = VER_PATCH;
                                add_frame(CMD_VERSION, LEN_VERSION, pay);
                            end else if (cmd_seen == REQ_ACK) begin
                                pay[0] = ACK_BYTE0;
                                pay[1] = ACK_BYTE1;
                                add_frame(CMD_ACK, LEN_ACK, pay);
                            end
                        end
                    end
                endcase
            end else begin
                // Both counts stick at full scale rather than wrapping.
                if (fast_count != 16'hFFFF) fast_count = fast_count + 16'd1;
                if (slow_count != 16'hFFFF) slow_count = slow_count + 16'd1;
                if (fast_count >= fast_period) begin
                    pos = int'($signed(it.steer));
                    ang = (pos + 500) * 10800 / 1000 - 5400;
                    a16 = ang[15:0];
                    pay[0] = a16[7:0];
                    pay[1] = a16[15:8];
                    add_frame(CMD_STEER, LEN_STEER, pay);
                    fast_count = 16'd0;
                end
                if (slow_count >= slow_period) begin
                    pay[0]  = DASH_TAG;
                    pay[1]  = it.rpm[15:8];
                    pay[2]  = it.rpm[7:0];
                    pay[3]  = 8'h00;
                    pay[4]  = 8'h00;
                    pay[5]  = it.battery[15:8];
                    pay[6]  = it.battery[7:0];
                    pay[7]  = it.temp[15:8];
                    pay[8]  = it.temp[7:0];
                    pay[9]  = 8'h00;
                    pay[10] = 8'h00;
                    pay[11] = DASH_FLAGS;
                    pay[12] = it.fuel;
                    add_frame(CMD_DASH, LEN_DASH, pay);
                    slow_count = 16'd0;
                end
                if (it.doors != doors_sent) begin
                    foreach (pay[i]) pay[i] = 8'h00;
                    pay[0] = DOOR_TAG;
                    // The door flags come out in reverse bit order.
                    pay[1] = {3'b000, it.doors[3], it.doors[4], it.doors[5],
                              it.doors[6], it.doors[7]};
                    add_frame(CMD_DASH, LEN_DASH, pay);
                    doors_sent = it.doors;
                end
            end
            if (frames_due.size() > first) begin
                w = frames_due.pop_back();
                w.last = 1'b1;
                frames_due.push_back(w);
            end
        endfunction

        function void match_word(logic [7:0] data, logic fe, logic lst);
            tx_word_t w;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected word %h (frame_end %b, last %b)", $time, data, fe, lst);
                errors++;
                return;
            end
            w = frames_due.pop_front();
            if (data !== w.data) begin
                $display("%0t: tx_byte expected %h, got %h", $time, w.data, data);
                errors++;
            end
            if (fe !== w.frame_end) begin
                $display("%0t: frame_end expected %b, got %b", $time, w.frame_end, fe);
                errors++;
            end
            if (lst !== w.last) begin
                $display("%0t: last expected %b, got %b", $time, w.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    link_item_t  offer     = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_frame_end;
    logic        m_last;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    tx_frame_board board;
    logic [7:0]    doors_now = DOORS_RESET;
    bit            calm = 1'b0;
    bit            hold_request = 1'b0;

    head_unit_frame_link dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_kind                (offer.kind),
        .s_rx_byte             (offer.rx_byte),
        .s_steer_position      (offer.steer),
        .s_engine_rpm          (offer.rpm),
        .s_battery_centivolts  (offer.battery),
        .s_outside_temp_tenths (offer.temp),
        .s_fuel_level          (offer.fuel),
        .s_door_bits           (offer.doors),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_tx_byte             (m_tx_byte),
        .m_frame_end           (m_frame_end),
        .m_last                (m_last),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_addr              (cfg_addr),
        .cfg_wdata             (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.take_item(offer);
            if (m_valid && m_ready) board.match_word(m_tx_byte, m_frame_end, m_last);
        end
    end

    // Receiver side: random stall bursts, runs of steady ready, and one long hold-off.
    always begin
        int pick;
        @(posedge aclk);
        pick = $urandom_range(0, 9);
        if (hold_request) begin
            hold_request = 1'b0;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            m_ready <= 1'b1;
        end else if (!calm && pick < 3) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            m_ready <= 1'b1;
        end else if (pick < 5) begin
            m_ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("head_unit_frame_link_test: done, errors");
        $finish;
    end

    function automatic link_item_t rx_of(logic [7:0] b);
        link_item_t it;
        it = 89'({$urandom, $urandom, $urandom});
        it.kind = KIND_RX;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic link_item_t tick_of(logic [15:0] steer, logic [15:0] rpm,
                                           logic [15:0] bat, logic [15:0] temp,
                                           logic [7:0] fuel, logic [7:0] doors);
        link_item_t it;
        it.kind    = KIND_TICK;
        it.rx_byte = 8'($urandom);
        it.steer   = steer;
        it.rpm     = rpm;
        it.battery = bat;
        it.temp    = temp;
        it.fuel    = fuel;
        it.doors   = doors;
        return it;
    endfunction

    function automatic link_item_t random_tick();
        int nominal;
        nominal = int'($urandom_range(0, 1000)) - 500;
        // Doors change now and then, so most ticks carry no door frame.
        if ($urandom_range(0, 3) == 0) doors_now = 8'($urandom);
        return tick_of($urandom_range(0, 1) ? 16'(nominal) : 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 8'($urandom), doors_now);
    endfunction

    task automatic send_item(input link_item_t it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        offer   <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_rx_frame(input logic [7:0] cmd, input int len);
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(cmd));
        send_item(rx_of(8'(len)));
        // Body and checksum, with stray header bytes that must not restart the parser.
        repeat (len + 1)
            send_item(rx_of($urandom_range(0, 7) == 0 ? HDR_BYTE : 8'($urandom)));
    endtask

    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.frames_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_periods(input logic [15:0] fast, input logic [15:0] slow);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FAST_PERIOD;
        cfg_wdata <= fast;
        @(posedge aclk);
        cfg_addr  <= CFG_SLOW_PERIOD;
        cfg_wdata <= slow;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_periods(fast, slow);
    endtask

    task automatic run_random(input int count);
        int pick;
        logic [7:0] cmd;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: cmd = REQ_VERSION;
                1: cmd = REQ_VERSION_ALT;
                2: cmd = REQ_ACK;
                default: cmd = 8'($urandom);
            endcase
            if (pick < 40) begin
                send_item(random_tick());
            end else if (pick < 75) begin
                send_rx_frame(cmd, $urandom_range(0, 6));
            end else if (pick < 87) begin
                send_item(rx_of(8'($urandom)));
            end else begin
                // A cut-off frame: the bytes that follow get parsed as its remainder.
                send_item(rx_of(HDR_BYTE));
                repeat ($urandom_range(0, 2)) send_item(rx_of(cmd));
            end
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset periods: no timer is due yet; door changes and known requests send.
        send_item(tick_of(16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'hFF));
        send_item(tick_of(16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'h00));
        send_item(tick_of(16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'hF8));
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(REQ_VERSION));
        send_item(rx_of(8'h00));
        send_item(rx_of(8'hFF));
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(REQ_VERSION_ALT));
        send_item(rx_of(8'h01));
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(8'h55));
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(REQ_ACK));
        send_item(rx_of(8'h00));
        send_item(rx_of(8'h00));
        send_item(rx_of(HDR_BYTE));
        send_item(rx_of(UNKNOWN_CMD));
        send_item(rx_of(8'h00));
        send_item(rx_of(8'h2E));
        wait_for_quiet();

        // Steering and dashboard due on every tick; doors send when they change.
        write_periods(16'd1, 16'd1);
        send_item(tick_of(16'h8000, 16'hFFFF, 16'h0000, 16'h8000, 8'hFF, 8'h07));
        send_item(tick_of(16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF, 8'h00, 8'h07));
        send_item(tick_of(-16'sd500, 16'h1234, 16'd1250, -16'sd1, 8'h80, 8'h07));
        send_item(tick_of(16'd500, 16'hABCD, 16'd1400, 16'd215, 8'h7F, 8'h50));
        wait_for_quiet();

        // The receiver holds off while ticks keep coming, so the job queue fills.
        hold_request = 1'b1;
        repeat (10) send_item(random_tick());
        run_random(9);
        wait_for_quiet();

        write_periods(16'hFFFF, 16'hFFFF);
        run_random(9);
        wait_for_quiet();

        // Counts built up under the long periods, so lowering them fires at once.
        write_periods(16'd2, 16'd5);
        run_random(9);
        wait_for_quiet();

        write_periods(16'd1, 16'hFFFF);
        send_rx_frame(REQ_ACK, 255);
        run_random(9);
        wait_for_quiet();

        write_periods(16'hFFFF, 16'd1);
        run_random(9);
        wait_for_quiet();

        write_periods(16'd4, 16'd9);
        calm = 1'b1;
        run_random(9);
        wait_for_quiet();

        if (board.errors == 0) begin
            $display("head_unit_frame_link_test: done, clean");
        end else begin
            $display("head_unit_frame_link_test: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/hufl_pkg.sv
rtl/core/hufl_front.sv
rtl/core/hufl_queue.sv
rtl/core/hufl_back.sv
rtl/core/head_unit_frame_link.sv
dv/head_unit_frame_link_test.sv
